### rtl/ising_spin_flip_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the lattice update block
// Clocked implication checks with an active-low reset that disables them.
// ----------------------------------------------------------------------------
`ifndef ISING_SPIN_FLIP_STEP_ASSERT_SVH
`define ISING_SPIN_FLIP_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/isfs_pkg.sv
// ----------------------------------------------------------------------------
// isfs_pkg
// Types, codes and coordinate wrap tables for the Ising spin-flip block.
// ----------------------------------------------------------------------------
package isfs_pkg;

    // Command codes carried in s_tuser.
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD = 2'd0;
    localparam cmd_t CMD_READ = 2'd1;
    localparam cmd_t CMD_FLIP = 2'd2;

    // Configuration register indexes.
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_THRESH_MINUS4 = 3'd0;
    localparam cfg_index_t REG_THRESH_MINUS2 = 3'd1;
    localparam cfg_index_t REG_THRESH_ZERO   = 3'd2;
    localparam cfg_index_t REG_THRESH_PLUS2  = 3'd3;
    localparam cfg_index_t REG_THRESH_PLUS4  = 3'd4;

    localparam int THRESH_W = 17;
    typedef logic [THRESH_W-1:0] thresh_t;
    typedef thresh_t [4:0] thresh_array_t;
    localparam thresh_t THRESH_RESET = 17'h10000;

    typedef struct packed {
        logic       we;
        cfg_index_t index;
        thresh_t    data;
    } cfg_wr_t;

    localparam int MAG_W = 14;

    // Site coordinates arrive as 6-bit fields; reduced coordinates fit in 10 bits.
    localparam int COORD_IN_W  = 6;
    localparam int COORD_COUNT = 64;
    localparam int COORD_MAX_W = 10;
    typedef logic [COORD_MAX_W-1:0] coord_table_t [COORD_COUNT];

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW2,
        ST_EVAL
    } state_t;

    // Entry i holds i modulo size, built by a wrapping counter.
    function automatic coord_table_t wrap_table(input int size);
        coord_table_t t;
        int           c;
        c = 0;
        for (int i = 0; i < COORD_COUNT; i++)
        begin
            t[i] = COORD_MAX_W'(c);
            c = (c == size - 1) ? 0 : c + 1;
        end
        return t;
    endfunction

endpackage

### rtl/isfs_lattice_ram.sv
// ----------------------------------------------------------------------------
// isfs_lattice_ram
// Row-wide lattice store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module isfs_lattice_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read on the same port.
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### rtl/isfs_thresh_regs.sv
// ----------------------------------------------------------------------------
// isfs_thresh_regs
// Five acceptance thresholds, one per value of spin times neighbor sum.
// ----------------------------------------------------------------------------
module isfs_thresh_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isfs_pkg::cfg_wr_t      cfg_wr,
    output isfs_pkg::thresh_array_t thresh
);
    import isfs_pkg::*;

    thresh_array_t thresh_reg;
    thresh_array_t thresh_next;

    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_wr.we)
        begin
            case (cfg_wr.index)
                REG_THRESH_MINUS4: thresh_next[0] = cfg_wr.data;
                REG_THRESH_MINUS2: thresh_next[1] = cfg_wr.data;
                REG_THRESH_ZERO:   thresh_next[2] = cfg_wr.data;
                REG_THRESH_PLUS2:  thresh_next[3] = cfg_wr.data;
                REG_THRESH_PLUS4:  thresh_next[4] = cfg_wr.data;
                default:           thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= {5{THRESH_RESET}};
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    assign thresh = thresh_reg;

endmodule

### rtl/ising_spin_flip_step.sv
// ----------------------------------------------------------------------------
// ising_spin_flip_step
// Metropolis single-spin-flip update of a periodic 2D Ising lattice.
//
//   channel   direction  handshake           payload (lowest bit first)
//   s_*       in         s_tvalid/s_tready   tuser: command; tdata: site_x,
//                                            site_y, spin_in, random_draw
//   m_*       out        m_tvalid/m_tready   tdata: spin_out, flipped,
//                                            magnetisation
//   cfg_*     in         cfg_we              cfg_addr selects a threshold
//
// An item passes through two reads of the row-wide lattice memory (rows
// y and y-1 together, then row y+1) and an evaluate and write-back step.
// After reset a clearing pass writes every row to all +1, during which no
// request is taken. A stalled result holds the block in the evaluate state;
// the next request is taken once the result is registered.
// ----------------------------------------------------------------------------
`include "ising_spin_flip_step_assert.svh"

module ising_spin_flip_step #(
    parameter int X_SIZE = 64,
    parameter int Y_SIZE = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // site_x, site_y, spin_in, random_draw
    input  logic [1:0]             s_tuser,   // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // spin_out, flipped, magnetisation
    input  logic                   cfg_we,
    input  isfs_pkg::cfg_index_t   cfg_addr,
    input  isfs_pkg::thresh_t      cfg_wdata
);
    import isfs_pkg::*;

    localparam int XW = $clog2(X_SIZE);
    localparam int YW = $clog2(Y_SIZE);
    localparam int SITES = X_SIZE * Y_SIZE;
    localparam logic [MAG_W-1:0] MAG_RESET = SITES[MAG_W-1:0];
    localparam coord_table_t X_WRAP = wrap_table(X_SIZE);
    localparam coord_table_t Y_WRAP = wrap_table(Y_SIZE);

    // Request fields.
    logic [COORD_IN_W-1:0] in_x;
    logic [COORD_IN_W-1:0] in_y;
    logic                  in_spin;
    logic [15:0]           in_draw;
    logic [XW-1:0]         x_mod;
    logic [XW-1:0]         x_left;
    logic [XW-1:0]         x_right;
    logic [YW-1:0]         y_mod;
    logic [YW-1:0]         y_up;
    logic [YW-1:0]         y_down;

    assign in_x    = s_tdata[5:0];
    assign in_y    = s_tdata[11:6];
    assign in_spin = s_tdata[12];
    assign in_draw = s_tdata[28:13];

    assign x_mod   = X_WRAP[in_x][XW-1:0];
    assign y_mod   = Y_WRAP[in_y][YW-1:0];
    assign x_left  = (x_mod == '0) ? XW'(X_SIZE - 1) : x_mod - XW'(1);
    assign x_right = (x_mod == XW'(X_SIZE - 1)) ? '0 : x_mod + XW'(1);
    assign y_up    = (y_mod == '0) ? YW'(Y_SIZE - 1) : y_mod - YW'(1);

    // Control state.
    state_t           state_reg, state_next;
    logic [YW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [MAG_W-1:0] mag_reg, mag_next;

    // Item payload.
    cmd_t             cmd_reg;
    logic [XW-1:0]    x_reg, xl_reg, xr_reg;
    logic [YW-1:0]    y_reg;
    logic             spin_in_reg;
    logic [15:0]      draw_reg;
    logic [X_SIZE-1:0] row_up_reg;
    logic             spin_out_reg;
    logic             flipped_reg;

    // Memory ports.
    logic              ram_we;
    logic [YW-1:0]     ram_waddr;
    logic [X_SIZE-1:0] ram_wdata;
    logic              ram_re_a, ram_re_b;
    logic [YW-1:0]     ram_raddr_b;
    logic [X_SIZE-1:0] row_mid, row_down;

    // Evaluation.
    thresh_array_t     thresh;
    cfg_wr_t           cfg_wr;
    logic              accept_req;
    logic              eval_done;
    logic              spin_old;
    logic [2:0]        ups;
    logic [2:0]        sel;
    thresh_t           thr;
    logic              draw_hit;
    logic              spin_new;
    logic              flip_hit;
    logic [X_SIZE-1:0] row_new;

    assign cfg_wr = '{we: cfg_we, index: cfg_addr, data: cfg_wdata};

    isfs_thresh_regs u_thresh (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .thresh (thresh)
    );

    isfs_lattice_ram #(
        .WIDTH (X_SIZE),
        .DEPTH (Y_SIZE)
    ) u_lattice (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (y_mod),
        .rdata_a (row_mid),
        .re_b    (ram_re_b),
        .raddr_b (ram_raddr_b),
        .rdata_b (row_down)
    );

    assign y_down = (y_reg == YW'(Y_SIZE - 1)) ? '0 : y_reg + YW'(1);

    // Spin update from the three rows.
    always_comb
    begin
        spin_old = row_mid[x_reg];
        ups = {2'b00, row_up_reg[x_reg]} + {2'b00, row_down[x_reg]}
            + {2'b00, row_mid[xl_reg]} + {2'b00, row_mid[xr_reg]};
        // Slot index is (k + 4) / 2 with k = spin times neighbor sum.
        sel = spin_old ? ups : 3'd4 - ups;
        case (sel)
            3'd0:    thr = thresh[0];
            3'd1:    thr = thresh[1];
            3'd2:    thr = thresh[2];
            3'd3:    thr = thresh[3];
            3'd4:    thr = thresh[4];
            default: thr = '0;
        endcase
        draw_hit = {1'b0, draw_reg} < thr;
        flip_hit = (cmd_reg == CMD_FLIP) && draw_hit;
        case (cmd_reg)
            CMD_LOAD: spin_new = spin_in_reg;
            CMD_FLIP: spin_new = spin_old ^ draw_hit;
            default:  spin_new = spin_old;
        endcase
        row_new = row_mid;
        row_new[x_reg] = spin_new;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == YW'(Y_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ROW2;
                end
            end
            ST_ROW2:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_tready    = 1'b0;
        ram_re_a    = 1'b0;
        ram_re_b    = 1'b0;
        ram_raddr_b = y_up;
        ram_we      = 1'b0;
        ram_waddr   = y_reg;
        ram_wdata   = row_new;
        eval_done   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ram_re_a = s_tvalid;
                ram_re_b = s_tvalid;
            end
            ST_ROW2:
            begin
                ram_re_b    = 1'b1;
                ram_raddr_b = y_down;
            end
            ST_EVAL:
            begin
                eval_done = !m_tvalid_reg || m_tready;
                ram_we    = eval_done;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept_req = s_tvalid && s_tready;

    always_comb
    begin
        clr_cnt_next  = (state_reg == ST_CLEAR) ? clr_cnt_reg + YW'(1) : clr_cnt_reg;
        m_tvalid_next = eval_done ? 1'b1 : (m_tvalid_reg && !m_tready);
        mag_next      = mag_reg;
        if (eval_done && (spin_new != spin_old))
        begin
            mag_next = spin_new ? mag_reg + MAG_W'(2) : mag_reg - MAG_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            mag_reg      <= MAG_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            mag_reg      <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_req)
        begin
            cmd_reg     <= s_tuser;
            x_reg       <= x_mod;
            xl_reg      <= x_left;
            xr_reg      <= x_right;
            y_reg       <= y_mod;
            spin_in_reg <= in_spin;
            draw_reg    <= in_draw;
        end
        if (state_reg == ST_ROW2)
        begin
            row_up_reg <= row_down;
        end
        if (eval_done)
        begin
            spin_out_reg <= spin_new;
            flipped_reg  <= flip_hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {mag_reg, flipped_reg, spin_out_reg};

    `ISFS_ASSERT_NEXT(a_accept_reads_row2, clk, rst_n, accept_req, state_reg == ST_ROW2,
        "accepted request did not move to the second row read")
    `ISFS_ASSERT_SAME(a_write_only_clear_eval, clk, rst_n, ram_we,
        (state_reg == ST_CLEAR) || (state_reg == ST_EVAL), "lattice written outside clear or evaluate")
    `ISFS_ASSERT_NEXT(a_mag_only_on_eval, clk, rst_n, !eval_done, $stable(mag_reg),
        "magnetisation changed without a completed request")
    `ISFS_ASSERT_SAME(a_flip_needs_flip_cmd, clk, rst_n, eval_done && flip_hit,
        cmd_reg == CMD_FLIP, "flip reported for a request that is not a flip attempt")

endmodule

### bench/ising_spin_flip_step_test.sv
// ----------------------------------------------------------------------------
// ising_spin_flip_step_test
// Streams load, read and flip requests into the Ising lattice block and
// checks every result against a lattice and magnetisation kept in the bench.
// Directed requests cover reset state, wrapped corners, the spare command
// and the threshold extremes. Random clusters of requests follow, with idle
// gaps on either side, a long output stall and pauses for a full drain.
// ----------------------------------------------------------------------------
module ising_spin_flip_step_test;
    import isfs_pkg::*;

    // The spare command code behaves as a read.
    localparam cmd_t CMD_SPARE      = 2'd3;
    localparam int   SETTLE_CYCLES  = 8;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   HOLD_CYCLES    = 150;
    localparam int   PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             flipped;
        logic             spin;
    } spin_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // site_x, site_y, spin_in, random_draw
    logic [1:0]  s_tuser   = CMD_READ; // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // spin_out, flipped, magnetisation
    logic        cfg_we    = 1'b0;
    cfg_index_t  cfg_addr  = REG_THRESH_MINUS4;
    thresh_t     cfg_wdata = '0;

    // Lattice, magnetisation and thresholds as the block should hold them.
    bit           spin_grid [64][64];
    int           mag_sum;
    thresh_t      thresh_model [5];
    spin_result_t expected_results [$];

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int flip_attempts   = 0;
    int flips_accepted  = 0;
    int loads_sent      = 0;
    int threshold_sets  = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int rx_hold_left    = 0;
    int stall_cycles    = 0;

    ising_spin_flip_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic spin_result_t apply_update(cmd_t cmd, logic [5:0] x, logic [5:0] y,
                                                  logic spin_in, logic [15:0] draw);
        spin_result_t r;
        logic [5:0]   xl;
        logic [5:0]   xr;
        logic [5:0]   yu;
        logic [5:0]   yd;
        int           ups;
        int           slot;
        xl = x - 6'd1;
        xr = x + 6'd1;
        yu = y - 6'd1;
        yd = y + 6'd1;
        r.flipped = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            loads_sent++;
            if (spin_grid[y][x] != spin_in)
            begin
                spin_grid[y][x] = spin_in;
                mag_sum += spin_in ? 2 : -2;
            end
        end
        else if (cmd == CMD_FLIP)
        begin
            flip_attempts++;
            ups = int'(spin_grid[y][xl]) + int'(spin_grid[y][xr])
                + int'(spin_grid[yu][x]) + int'(spin_grid[yd][x]);
            // Slot (k + 4) / 2: up neighbors for an up spin, down ones otherwise.
            slot = spin_grid[y][x] ? ups : 4 - ups;
            if ({1'b0, draw} < thresh_model[slot])
            begin
                spin_grid[y][x] = !spin_grid[y][x];
                mag_sum += spin_grid[y][x] ? 2 : -2;
                r.flipped = 1'b1;
                flips_accepted++;
            end
        end
        r.spin = spin_grid[y][x];
        r.mag  = mag_sum[MAG_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < PRINT_LIMIT)
            $display("mismatch on result %0d: %s got %0d, expected %0d",
                     results_checked, what, got, want);
        errors++;
    endtask

    task automatic check_result(logic [15:0] data);
        spin_result_t got;
        spin_result_t want;
        got = spin_result_t'(data);
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no request pending", int'(data), 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.spin !== want.spin)
            report_mismatch("spin_out", int'(got.spin), int'(want.spin));
        if (got.flipped !== want.flipped)
            report_mismatch("flipped", int'(got.flipped), int'(want.flipped));
        if (got.mag !== want.mag)
            report_mismatch("magnetisation", int'($signed(got.mag)), int'($signed(want.mag)));
        results_checked++;
    endtask

    // Result side: random or held-off ready, and a check on every transfer.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_result(m_tdata);
        if (rx_hold_left > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("ising_spin_flip_step_test failed");
            $finish;
        end
    end

    task automatic send_request(cmd_t cmd, logic [5:0] x, logic [5:0] y,
                                logic spin_in, logic [15:0] draw);
        // Each cycle before the offer, the sender idles with the set chance.
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, draw, spin_in, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(apply_update(cmd, x, y, spin_in, draw));
        items_sent++;
    endtask

    // Stop offering requests and let every outstanding result come back.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_threshold(cfg_index_t idx, thresh_t value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        thresh_model[idx] = value;
    endtask

    task automatic set_thresholds(thresh_t m4, thresh_t m2, thresh_t z,
                                  thresh_t p2, thresh_t p4);
        wait_for_idle();
        put_threshold(REG_THRESH_MINUS4, m4);
        put_threshold(REG_THRESH_MINUS2, m2);
        put_threshold(REG_THRESH_ZERO, z);
        put_threshold(REG_THRESH_PLUS2, p2);
        put_threshold(REG_THRESH_PLUS4, p4);
        cfg_we <= 1'b0;
        @(posedge clk);
        threshold_sets++;
    endtask

    function automatic thresh_t pick_threshold();
        case ($urandom_range(6))
            0:       return '0;
            1:       return thresh_t'(1);
            2:       return thresh_t'(65535);
            3:       return THRESH_RESET;
            4:       return '1;
            5:       return thresh_t'($urandom_range(65535));
            default: return thresh_t'($urandom);
        endcase
    endfunction

    // Most requests land around a cluster center so that loads shape the
    // neighborhoods that later flip attempts see.
    task automatic send_random_request(logic [5:0] cx, logic [5:0] cy);
        int         r;
        cmd_t       cmd;
        logic [5:0] x;
        logic [5:0] y;
        r = $urandom_range(99);
        if (r < 25)
            cmd = CMD_LOAD;
        else if (r < 70)
            cmd = CMD_FLIP;
        else if (r < 90)
            cmd = CMD_READ;
        else
            cmd = CMD_SPARE;
        if ($urandom_range(4) == 0)
        begin
            x = 6'($urandom);
            y = 6'($urandom);
        end
        else
        begin
            x = cx + 6'($urandom_range(2)) - 6'd1;
            y = cy + 6'($urandom_range(2)) - 6'd1;
        end
        send_request(cmd, x, y, 1'($urandom), 16'($urandom));
    endtask

    task automatic test_reset_state();
        send_request(CMD_READ, 6'd0, 6'd0, 1'b0, 16'h0000);
        send_request(CMD_READ, 6'd63, 6'd63, 1'b1, 16'hFFFF);
        send_request(CMD_SPARE, 6'd63, 6'd0, 1'b1, 16'hFFFF);
        send_request(CMD_LOAD, 6'd5, 6'd5, 1'b1, 16'h0000);
    endtask

    task automatic test_loads_and_flips();
        send_request(CMD_LOAD, 6'd0, 6'd0, 1'b0, 16'h0000);
        send_request(CMD_LOAD, 6'd63, 6'd0, 1'b0, 16'hFFFF);
        send_request(CMD_READ, 6'd63, 6'd0, 1'b0, 16'h0000);
        // Corner sites pull neighbors from the opposite edges.
        send_request(CMD_FLIP, 6'd0, 6'd63, 1'b0, 16'hFFFF);
        send_request(CMD_FLIP, 6'd0, 6'd0, 1'b1, 16'h0000);
        send_request(CMD_FLIP, 6'd32, 6'd32, 1'b0, 16'hFFFF);
        send_request(CMD_FLIP, 6'd32, 6'd32, 1'b1, 16'hFFFF);
        send_request(CMD_LOAD, 6'd31, 6'd32, 1'b0, 16'h5A5A);
    endtask

    task automatic test_threshold_extremes();
        set_thresholds('0, '0, '0, '0, '0);
        send_request(CMD_FLIP, 6'd32, 6'd32, 1'b0, 16'h0000);
        send_request(CMD_FLIP, 6'd0, 6'd0, 1'b0, 16'h0000);
        set_thresholds('1, '1, '1, '1, '1);
        send_request(CMD_FLIP, 6'd40, 6'd40, 1'b0, 16'hFFFF);
        set_thresholds(thresh_t'(1), thresh_t'(1), thresh_t'(1), thresh_t'(1), thresh_t'(1));
        send_request(CMD_FLIP, 6'd40, 6'd40, 1'b0, 16'h0000);
        send_request(CMD_FLIP, 6'd40, 6'd40, 1'b0, 16'h0001);
        set_thresholds(thresh_t'(65535), thresh_t'(65535), thresh_t'(65535),
                       thresh_t'(65535), thresh_t'(65535));
        send_request(CMD_FLIP, 6'd40, 6'd40, 1'b0, 16'hFFFF);
        send_request(CMD_FLIP, 6'd40, 6'd40, 1'b0, 16'hFFFE);
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, int count);
        logic [5:0] cx;
        logic [5:0] cy;
        set_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                       pick_threshold(), pick_threshold());
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        cx = '0;
        cy = '0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                cx = 6'($urandom);
                cy = 6'($urandom);
            end
            send_random_request(cx, cy);
        end
        wait_for_idle();
    endtask

    // The result side holds off long enough for the block to stall its input.
    task automatic test_output_stall();
        logic [5:0] cx;
        logic [5:0] cy;
        cx = 6'($urandom);
        cy = 6'($urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_left  = HOLD_CYCLES;
        repeat (30) send_random_request(cx, cy);
        wait_for_idle();
    endtask

    task automatic test_drain_pause();
        logic [5:0] cx;
        logic [5:0] cy;
        send_idle_pct = 10;
        recv_idle_pct = 50;
        repeat (3)
        begin
            cx = 6'($urandom);
            cy = 6'($urandom);
            repeat (10) send_random_request(cx, cy);
            wait_for_idle();
        end
    endtask

    initial
    begin
        for (int yy = 0; yy < 64; yy++)
            for (int xx = 0; xx < 64; xx++)
                spin_grid[yy][xx] = 1'b1;
        mag_sum = 4096;
        for (int i = 0; i < 5; i++)
            thresh_model[i] = THRESH_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // The block clears its lattice before it takes the first request.
        while (!s_tready)
            @(posedge clk);

        test_reset_state();
        test_loads_and_flips();
        test_threshold_extremes();
        run_random_phase(26, 83, 130);
        run_random_phase(83, 26, 130);
        run_random_phase(0, 0, 80);
        test_output_stall();
        test_drain_pause();
        wait_for_idle();

        $display("covered %0d requests: %0d loads, %0d flip attempts (%0d accepted)",
                 items_sent, loads_sent, flip_attempts, flips_accepted);
        $display("checked %0d results over %0d threshold settings, final magnetisation %0d",
                 results_checked, threshold_sets, mag_sum);
        if (errors == 0 && expected_results.size() == 0)
            $display("ising_spin_flip_step_test passed");
        else
            $display("ising_spin_flip_step_test failed");
        $finish;
    end

endmodule

### ising_spin_flip_step.f
+incdir+rtl
rtl/isfs_pkg.sv
rtl/isfs_lattice_ram.sv
rtl/isfs_thresh_regs.sv
rtl/ising_spin_flip_step.sv
bench/ising_spin_flip_step_test.sv
